// File: src/virtual_region_table_unit_assert.svh
// assertion macros for the region table
`ifndef VIRTUAL_REGION_TABLE_UNIT_ASSERT_SVH
`define VIRTUAL_REGION_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clock, quiet in reset
`define VRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/vrt_pkg.sv
package vrt_pkg;

   localparam int ADDR_W          = 32;
   localparam int PAGE_SHIFT      = 12;
   localparam int PAGES_W         = ADDR_W - PAGE_SHIFT;
   localparam int MAX_REGIONS_DEF = 64;

   // request kinds
   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_CHECK   = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_LEN  = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_FINISH
   } state_type;

   // token that walks the row of cells
   typedef struct packed {
      logic                active;
      logic                found;
      logic                hit_last;
      logic [ADDR_W-1:0]   last_end;
      logic [PAGES_W-1:0]  pages;
   } probe_type;

   // request held for the walk, seen by every cell
   typedef struct packed {
      logic                release_op;
      logic                check_op;
      logic [ADDR_W-1:0]   address;
   } cell_cmd_type;

endpackage

// File: src/vrt_if.sv
interface vrt_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic [vrt_pkg::ADDR_W-1:0]   length;
   logic [vrt_pkg::ADDR_W-1:0]   address;

   modport source (output valid, req_type, length, address, input ready);
   modport sink   (input valid, req_type, length, address, output ready);
endinterface

interface vrt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [vrt_pkg::ADDR_W-1:0]   start_address;
   logic                         in_region;
   logic [vrt_pkg::PAGES_W-1:0]  pages_freed;
   logic [1:0]                   status;

   modport source (output valid, start_address, in_region, pages_freed, status,
                   input ready);
   modport sink   (input valid, start_address, in_region, pages_freed, status,
                   output ready);
endinterface

// File: src/vrt_cell.sv
module vrt_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7,
   parameter bit LAST  = 1'b0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  vrt_pkg::probe_type           probe_in,
   output vrt_pkg::probe_type           probe_out,
   input  vrt_pkg::cell_cmd_type        cmd,
   input  logic [CNT_W-1:0]             count,
   input  logic                         wr_en,
   input  logic [vrt_pkg::ADDR_W-1:0]   wr_start,
   input  logic [vrt_pkg::ADDR_W-1:0]   wr_length,
   input  logic [vrt_pkg::ADDR_W-1:0]   next_start,
   input  logic [vrt_pkg::ADDR_W-1:0]   next_length,
   output logic [vrt_pkg::ADDR_W-1:0]   entry_start,
   output logic [vrt_pkg::ADDR_W-1:0]   entry_length
);

   vrt_pkg::probe_type           probe_ff;
   logic [vrt_pkg::ADDR_W-1:0]   start_ff, start_in;
   logic [vrt_pkg::ADDR_W-1:0]   length_ff, length_in;
   logic                         valid;
   logic                         hit_rel;
   logic                         hit_chk;
   logic                         in_range;
   logic [vrt_pkg::ADDR_W-1:0]   offset;

   assign valid    = CNT_W'(INDEX) < count;
   assign offset   = cmd.address - start_ff;
   assign in_range = (cmd.address >= start_ff) && (offset < length_ff);
   assign hit_rel  = probe_ff.active && cmd.release_op && valid && !probe_ff.found &&
                     (start_ff == cmd.address);
   assign hit_chk  = probe_ff.active && cmd.check_op && valid && !probe_ff.found &&
                     in_range;

   always_comb begin
      probe_out          = probe_ff;
      probe_out.found    = probe_ff.found | hit_rel | hit_chk;
      probe_out.hit_last = probe_ff.hit_last | (hit_rel && (CNT_W'(INDEX + 1) == count));
      if (hit_rel) begin
         probe_out.pages = length_ff[vrt_pkg::ADDR_W-1:vrt_pkg::PAGE_SHIFT];
      end
      // end of the latest valid entry ahead of any hit
      if (valid && !probe_out.found) begin
         probe_out.last_end = start_ff + length_ff;
      end
   end

   // compaction: from the hit onwards each entry takes its upper neighbour
   always_comb begin
      start_in  = start_ff;
      length_in = length_ff;
      if (wr_en && (CNT_W'(INDEX) == count)) begin
         start_in  = wr_start;
         length_in = wr_length;
      end else if (!LAST && probe_ff.active && cmd.release_op && probe_out.found) begin
         start_in  = next_start;
         length_in = next_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
      start_ff  <= start_in;
      length_ff <= length_in;
   end

   assign entry_start  = start_ff;
   assign entry_length = length_ff;

endmodule

// File: src/virtual_region_table_unit.sv
// allocate and unknown kinds: the word passes through S_EXEC, then S_FINISH moves the result out
// release and check: a token walks all MAX_REGIONS cells in S_WALK, then S_FINISH moves the result out
// one request in flight; the next word is taken once the result sits in the output register
// the token walk advances one cell per cycle
// synchronous reset empties the table and clears pool_base; entry contents keep no reset
module virtual_region_table_unit #(
   parameter int MAX_REGIONS = vrt_pkg::MAX_REGIONS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   vrt_req_if.sink                      req_ch,
   vrt_rsp_if.source                    rsp_ch,
   input  logic                         csr_we,
   input  logic [vrt_pkg::ADDR_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int AW    = vrt_pkg::ADDR_W;
   localparam int PW    = vrt_pkg::PAGES_W;

   // fsm
   vrt_pkg::state_type  state_ff, state_in;

   // held request word
   logic [1:0]          op_ff, op_in;
   logic [AW-1:0]       len_ff, len_in;
   logic [AW-1:0]       addr_ff, addr_in;

   // table bookkeeping
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [AW-1:0]       tail_ff, tail_in;      // end of the last entry
   logic [AW-1:0]       pool_base_ff, pool_base_in;

   // finished result, waiting for the output register
   logic [AW-1:0]       res_start_ff, res_start_in;
   logic                res_in_ff, res_in_in;
   logic [PW-1:0]       res_pages_ff, res_pages_in;
   logic [1:0]          res_status_ff, res_status_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]       rsp_start_ff, rsp_start_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [PW-1:0]       rsp_pages_ff, rsp_pages_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                req_take;
   logic                walk_kind;
   logic                rsp_free;
   logic                launch;
   logic                wr_en;
   logic [AW-1:0]       new_start;

   vrt_pkg::probe_type     launch_probe;
   vrt_pkg::probe_type     tail_probe;
   vrt_pkg::cell_cmd_type  cmd;

   vrt_pkg::probe_type     chain_probe [MAX_REGIONS+1];
   logic [AW-1:0]          cell_start  [MAX_REGIONS];
   logic [AW-1:0]          cell_length [MAX_REGIONS];

   assign req_take  = req_ch.valid && req_ch.ready;
   assign walk_kind = (req_ch.req_type == vrt_pkg::REQ_RELEASE) ||
                      (req_ch.req_type == vrt_pkg::REQ_CHECK);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign new_start = (count_ff == '0) ? pool_base_ff : tail_ff;

   assign cmd.release_op = (op_ff == vrt_pkg::REQ_RELEASE);
   assign cmd.check_op   = (op_ff == vrt_pkg::REQ_CHECK);
   assign cmd.address    = addr_ff;

   always_comb begin
      launch_probe        = '0;
      launch_probe.active = launch;
   end

   // row of cells, the token enters at cell 0 with the request word
   assign chain_probe[0] = launch_probe;
   assign tail_probe     = chain_probe[MAX_REGIONS];

   for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
      logic [AW-1:0] nxt_start;
      logic [AW-1:0] nxt_length;
      if (k == MAX_REGIONS - 1) begin : g_top
         assign nxt_start  = '0;
         assign nxt_length = '0;
      end else begin : g_mid
         assign nxt_start  = cell_start[k+1];
         assign nxt_length = cell_length[k+1];
      end
      vrt_cell #(
         .INDEX (k),
         .CNT_W (CNT_W),
         .LAST  (k == MAX_REGIONS - 1)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .probe_in     (chain_probe[k]),
         .probe_out    (chain_probe[k+1]),
         .cmd          (cmd),
         .count        (count_ff),
         .wr_en        (wr_en),
         .wr_start     (new_start),
         .wr_length    (len_ff),
         .next_start   (nxt_start),
         .next_length  (nxt_length),
         .entry_start  (cell_start[k]),
         .entry_length (cell_length[k])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vrt_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = walk_kind ? vrt_pkg::S_WALK : vrt_pkg::S_EXEC;
            end
         end
         vrt_pkg::S_EXEC: begin
            state_in = vrt_pkg::S_FINISH;
         end
         vrt_pkg::S_WALK: begin
            if (tail_probe.active) begin
               state_in = vrt_pkg::S_FINISH;
            end
         end
         vrt_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = vrt_pkg::S_IDLE;
            end
         end
         default: state_in = vrt_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ch.ready  = 1'b0;
      launch        = 1'b0;
      wr_en         = 1'b0;
      op_in         = op_ff;
      len_in        = len_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      tail_in       = tail_ff;
      res_start_in  = res_start_ff;
      res_in_in     = res_in_ff;
      res_pages_in  = res_pages_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_start_in  = rsp_start_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_status_in = rsp_status_ff;
      pool_base_in  = csr_we ? csr_wdata : pool_base_ff;

      unique case (state_ff)
         vrt_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_take) begin
               op_in   = req_ch.req_type;
               len_in  = req_ch.length;
               addr_in = req_ch.address;
               launch  = walk_kind;
               res_start_in  = '0;
               res_in_in     = 1'b0;
               res_pages_in  = '0;
               res_status_in = vrt_pkg::STATUS_OK;
            end
         end
         vrt_pkg::S_EXEC: begin
            // allocate, or the unused kind that answers all zero
            if (op_ff == vrt_pkg::REQ_ALLOC) begin
               if (len_ff == '0) begin
                  res_status_in = vrt_pkg::STATUS_ZERO_LEN;
               end else if (count_ff == CNT_W'(MAX_REGIONS)) begin
                  res_status_in = vrt_pkg::STATUS_FULL;
               end else begin
                  wr_en        = 1'b1;
                  res_start_in = new_start;
                  count_in     = count_ff + CNT_W'(1);
                  tail_in      = new_start + len_ff;
               end
            end
         end
         vrt_pkg::S_WALK: begin
            if (tail_probe.active) begin
               if (cmd.check_op) begin
                  res_in_in = tail_probe.found;
               end else if (tail_probe.found) begin
                  res_pages_in = tail_probe.pages;
                  count_in     = count_ff - CNT_W'(1);
                  // removing the last entry moves the end back to the one below
                  if (tail_probe.hit_last) begin
                     tail_in = tail_probe.last_end;
                  end
               end else begin
                  res_status_in = vrt_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         vrt_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = res_start_ff;
               rsp_hit_in    = res_in_ff;
               rsp_pages_in  = res_pages_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrt_pkg::S_IDLE;
         count_ff     <= '0;
         pool_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pool_base_ff <= pool_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      len_ff        <= len_in;
      addr_ff       <= addr_in;
      tail_ff       <= tail_in;
      res_start_ff  <= res_start_in;
      res_in_ff     <= res_in_in;
      res_pages_ff  <= res_pages_in;
      res_status_ff <= res_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_status_ff <= rsp_status_in;
   end

   // result channel
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.start_address = rsp_start_ff;
   assign rsp_ch.in_region     = rsp_hit_ff;
   assign rsp_ch.pages_freed   = rsp_pages_ff;
   assign rsp_ch.status        = rsp_status_ff;

endmodule

// File: src/vrt_checker.sv
`include "virtual_region_table_unit_assert.svh"

module vrt_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [vrt_pkg::ADDR_W-1:0]    rsp_start_address,
   input  logic                          rsp_in_region,
   input  logic [vrt_pkg::PAGES_W-1:0]   rsp_pages_freed,
   input  logic [1:0]                    rsp_status
);

   localparam int WORD_W = vrt_pkg::ADDR_W + vrt_pkg::PAGES_W + 3;

   logic              rsp_stall;
   logic              req_take;
   logic              chk_clean;
   logic              pages_nz;
   logic              status_ok;
   logic [WORD_W-1:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_word  = {rsp_start_address, rsp_in_region, rsp_pages_freed, rsp_status};
   assign status_ok = (rsp_status == vrt_pkg::STATUS_OK);
   assign pages_nz  = (rsp_pages_freed != '0);
   assign chk_clean = !pages_nz && (rsp_start_address == '0) && status_ok;

   `VRT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "word lost in stall")
   `VRT_ASSERT_NEXT(a_one_in_flight, req_take, !req_ready, "word taken while busy")
   `VRT_ASSERT_NOW(a_check_only, rsp_valid && rsp_in_region, chk_clean, "check hit not clean")
   `VRT_ASSERT_NOW(a_free_ok, rsp_valid && pages_nz, status_ok, "pages freed on failed request")

endmodule

bind virtual_region_table_unit vrt_checker u_vrt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_start_address (rsp_ch.start_address),
   .rsp_in_region     (rsp_ch.in_region),
   .rsp_pages_freed   (rsp_ch.pages_freed),
   .rsp_status        (rsp_ch.status)
);
